FILE: design/tmbu_pkg.sv
// ---------------------------------------------------------------------------
// tmbu_pkg
// Shared types and constants of the tiled masked bitplane unpacker.
// ---------------------------------------------------------------------------
package tmbu_pkg;

    localparam int MAX_LINE_BYTES = 128;
    localparam int MAX_PLANES     = 8;
    localparam int TILE_ROWS_CAP  = 1024;

    localparam int LB_W    = 8;   // line_bytes register
    localparam int TR_W    = 11;  // tile_rows register
    localparam int TH_W    = 8;   // tile_height register
    localparam int PC_W    = 4;   // plane_count register
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 11;  // widest register
    localparam int IDX_W   = 3;   // register index
    localparam int GROUP   = 8;   // positions per item
    localparam int VB_W    = GROUP * BYTE_W;
    localparam int COL_W   = $clog2(MAX_LINE_BYTES);
    localparam int TROW_W  = $clog2(TILE_ROWS_CAP);
    localparam int PLANE_W = 3;
    localparam int BIDX_W  = 17;

    typedef enum logic [IDX_W-1:0] {
        CFG_LINE_BYTES  = 3'd0,
        CFG_TILE_ROWS   = 3'd1,
        CFG_TILE_HEIGHT = 3'd2,
        CFG_PLANE_COUNT = 3'd3,
        CFG_FIRST_VALUE = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [LB_W-1:0]   line_bytes;
        logic [TR_W-1:0]   tile_rows;
        logic [TH_W-1:0]   tile_height;
        logic [PC_W-1:0]   plane_count;
    } t_cfg;

    // first_value write also reloads the held value in the front end
    typedef struct packed {
        logic              load;
        logic [BYTE_W-1:0] value;
    } t_fv_load;

    // one classified item: bytes already resolved per position
    typedef struct packed {
        logic            drop;
        logic [VB_W-1:0] bytes;
    } t_q_entry;

endpackage

FILE: design/tmbu_front.sv
// ---------------------------------------------------------------------------
// tmbu_front
// Accepts items, applies mask reload and resolves the byte of each position.
// ---------------------------------------------------------------------------
module tmbu_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tmbu_pkg::t_cfg                i_cfg,
    input  tmbu_pkg::t_fv_load            i_fv,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_reload_mask,
    input  logic [7:0]                    i_mask_byte,
    input  logic [63:0]                   i_value_bytes,
    input  logic                          i_q_full,
    output logic                          o_push,
    output tmbu_pkg::t_q_entry            o_entry
);
    import tmbu_pkg::*;

    logic [BYTE_W-1:0] r_mask;
    logic [BYTE_W-1:0] r_value;
    logic [BYTE_W-1:0] n_value;
    logic [BYTE_W-1:0] w_mask;
    logic [VB_W-1:0]   w_bytes;
    logic              w_drop;

    assign w_drop = (i_cfg.line_bytes == '0) || (i_cfg.tile_rows == '0) ||
                    (i_cfg.tile_height == '0) || (i_cfg.plane_count == '0);
    assign w_mask = i_reload_mask ? i_mask_byte : r_mask;

    // position r uses mask bit 7-r; set bits consume value bytes in order
    always_comb begin
        logic [BYTE_W-1:0] cur;
        logic [2:0]        cnt;
        cur     = r_value;
        cnt     = '0;
        w_bytes = '0;
        for (int r = 0; r < GROUP; r++) begin
            if (w_mask[GROUP-1-r]) begin
                cur = i_value_bytes[{cnt, 3'b000} +: BYTE_W];
                cnt = cnt + 3'd1;
            end
            w_bytes[r*BYTE_W +: BYTE_W] = cur;
        end
        n_value = cur;
    end

    assign o_stall       = i_q_full;
    assign o_push        = i_valid && !i_q_full;
    assign o_entry.drop  = w_drop;
    assign o_entry.bytes = w_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_value <= '0;
        end else begin
            if (i_fv.load) begin
                r_value <= i_fv.value;
            end else if (o_push && !w_drop) begin
                r_value <= n_value;
            end
            if (o_push && !w_drop && i_reload_mask) begin
                r_mask <= i_mask_byte;
            end
        end
    end

endmodule

FILE: design/tmbu_queue.sv
// ---------------------------------------------------------------------------
// tmbu_queue
// Two-entry queue between the front end and the back end.
// ---------------------------------------------------------------------------
module tmbu_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tmbu_pkg::t_q_entry   i_entry,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output tmbu_pkg::t_q_entry   o_entry
);
    import tmbu_pkg::*;

    t_q_entry   r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop) else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3) else $error("queue count out of range");

endmodule

FILE: design/tmbu_back.sv
// ---------------------------------------------------------------------------
// tmbu_back
// Walks picture positions; one result per cycle, two stages, unless stalled.
// ---------------------------------------------------------------------------
module tmbu_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tmbu_pkg::t_cfg                i_cfg,
    input  logic                          i_q_valid,
    input  tmbu_pkg::t_q_entry            i_q_entry,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_plane,
    output logic [16:0]                   o_byte_index,
    output logic [7:0]                    o_pixel_byte,
    output logic                          o_last_of_group,
    output logic                          o_picture_done
);
    import tmbu_pkg::*;

    // position counters and current item
    logic [PLANE_W-1:0] r_plane;
    logic [TROW_W-1:0]  r_trow;
    logic [COL_W-1:0]   r_col;
    logic [TH_W-1:0]    r_rit;
    logic               r_finished;
    logic               r_busy;
    logic [2:0]         r_k;
    logic [VB_W-1:0]    r_bytes;

    // stage 1: line computed
    logic               r_s1_valid;
    logic [BIDX_W-1:0]  r_s1_line;
    logic [COL_W-1:0]   r_s1_col;
    logic [PLANE_W-1:0] r_s1_plane;
    logic [BYTE_W-1:0]  r_s1_byte;
    logic               r_s1_last;
    logic               r_s1_done;

    // output register
    logic               r_out_valid;
    logic [PLANE_W-1:0] r_out_plane;
    logic [BIDX_W-1:0]  r_out_idx;
    logic [BYTE_W-1:0]  r_out_byte;
    logic               r_out_last;
    logic               r_out_done;

    logic [LB_W-1:0]    w_eff_lb;
    logic [TR_W-1:0]    w_eff_tr;
    logic [PC_W-1:0]    w_eff_pc;
    logic               w_en;
    logic               w_emit;
    logic               w_row_wrap;
    logic               w_col_wrap;
    logic               w_trow_wrap;
    logic               w_fin_set;
    logic               w_row_last;
    logic               w_free;
    logic               w_fin_now;
    logic [17:0]        w_prod;
    logic [BIDX_W-1:0]  w_line;
    logic [24:0]        w_iprod;
    logic [BIDX_W-1:0]  w_idx;

    assign w_eff_lb = (i_cfg.line_bytes > LB_W'(MAX_LINE_BYTES)) ?
                      LB_W'(MAX_LINE_BYTES) : i_cfg.line_bytes;
    assign w_eff_tr = (i_cfg.tile_rows > TR_W'(TILE_ROWS_CAP)) ?
                      TR_W'(TILE_ROWS_CAP) : i_cfg.tile_rows;
    assign w_eff_pc = (i_cfg.plane_count > PC_W'(MAX_PLANES)) ?
                      PC_W'(MAX_PLANES) : i_cfg.plane_count;

    // whole result pipeline moves unless the output is held
    assign w_en   = !r_out_valid || !i_stall;
    assign w_emit = r_busy && w_en;

    // a counter at or past its limit wraps on its next advance
    assign w_row_wrap  = !(({1'b0, r_rit} + 9'd1) < {1'b0, i_cfg.tile_height});
    assign w_col_wrap  = !(({1'b0, r_col} + 8'd1) < w_eff_lb);
    assign w_trow_wrap = !(({1'b0, r_trow} + 11'd1) < w_eff_tr);
    assign w_fin_set   = w_row_wrap && w_col_wrap && w_trow_wrap &&
                         !(({1'b0, r_plane} + 4'd1) < w_eff_pc);
    assign w_row_last  = (r_k == 3'd7) || w_fin_set;

    assign w_free    = !r_busy || (w_emit && w_row_last);
    assign o_pop     = w_free && i_q_valid;
    assign w_fin_now = r_finished || (w_emit && w_fin_set);

    assign w_prod = {8'd0, r_trow} * {10'd0, i_cfg.tile_height};
    assign w_line = w_prod[BIDX_W-1:0] + {9'd0, r_rit};

    assign w_iprod = {8'd0, r_s1_line} * {17'd0, w_eff_lb};
    assign w_idx   = w_iprod[BIDX_W-1:0] + {10'd0, r_s1_col};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane     <= '0;
            r_trow      <= '0;
            r_col       <= '0;
            r_rit       <= '0;
            r_finished  <= 1'b0;
            r_busy      <= 1'b0;
            r_k         <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_rit <= w_row_wrap ? '0 : r_rit + 8'd1;
                if (w_row_wrap) begin
                    r_col <= w_col_wrap ? '0 : r_col + 7'd1;
                    if (w_col_wrap) begin
                        r_trow <= w_trow_wrap ? '0 : r_trow + 10'd1;
                        if (w_trow_wrap) begin
                            r_plane <= w_fin_set ? '0 : r_plane + 3'd1;
                        end
                    end
                end
                if (w_fin_set) begin
                    r_finished <= 1'b1;
                end
            end
            // the last position of a group leaves the count to the next load
            if (w_emit && !w_row_last) begin
                r_k <= r_k + 3'd1;
            end
            if (w_free) begin
                if (i_q_valid && !i_q_entry.drop && !w_fin_now) begin
                    r_busy <= 1'b1;
                    r_k    <= '0;
                end else begin
                    r_busy <= 1'b0;
                end
            end
            if (w_en) begin
                r_s1_valid  <= w_emit;
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bytes <= i_q_entry.bytes;
        end
        if (w_en) begin
            r_s1_line   <= w_line;
            r_s1_col    <= r_col;
            r_s1_plane  <= r_plane;
            r_s1_byte   <= r_bytes[{r_k, 3'b000} +: BYTE_W];
            r_s1_last   <= w_row_last;
            r_s1_done   <= w_fin_set;
            r_out_plane <= r_s1_plane;
            r_out_idx   <= w_idx;
            r_out_byte  <= r_s1_byte;
            r_out_last  <= r_s1_last;
            r_out_done  <= r_s1_done;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_plane         = r_out_plane;
    assign o_byte_index    = r_out_idx;
    assign o_pixel_byte    = r_out_byte;
    assign o_last_of_group = r_out_last;
    assign o_picture_done  = r_out_done;

    a_busy_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_finished) else $error("walking positions after picture end");
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> r_out_last)
        else $error("picture end not marked as last of group");
    a_done_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_fin_set) |=> (r_finished && !r_busy))
        else $error("finish not recorded");
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && (r_k == 3'd7) && !o_pop) |=> !r_busy)
        else $error("group runs past eight positions");

endmodule

FILE: design/tiled_masked_bitplane_unpack.sv
// ---------------------------------------------------------------------------
// tiled_masked_bitplane_unpack
// Masked bitplane group decoder: front end, queue, position walker.
// ---------------------------------------------------------------------------
// Input channel (i_valid / o_stall): one item per group of eight positions,
// with an optional mask reload and up to eight value bytes.
// Output channel (o_valid / i_stall): one result per position, carrying the
// plane, byte index within the plane and decoded byte, with group-end and
// picture-end flags.
// Config channel (i_cfg_valid / o_cfg_ready, ready always high): register
// index and data; write only while the block is idle.
// An accepted item passes the queue, the walker, stage 1 and the output
// register before its first result shows. Results leave one per cycle
// unless stalled; an item that yields no result just frees the walker.
// A two-entry queue lets the front end keep taking items while results are
// stalled; the input stalls only when that queue is full.
// When the receiver stalls, the output register and the pipeline behind it
// hold, and the walker pauses.
// Reset (synchronous, active low) restores the default registers, clears the
// mask, held value, position counters and the picture-done state.
// ---------------------------------------------------------------------------
module tiled_masked_bitplane_unpack (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_reload_mask,
    input  logic [7:0]  i_mask_byte,
    input  logic [63:0] i_value_bytes,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_plane,
    output logic [16:0] o_byte_index,
    output logic [7:0]  o_pixel_byte,
    output logic        o_last_of_group,
    output logic        o_picture_done
);
    import tmbu_pkg::*;

    t_cfg      r_cfg;
    t_fv_load  w_fv;
    t_q_entry  w_push_entry;
    t_q_entry  w_head;
    logic      w_push;
    logic      w_pop;
    logic      w_full;
    logic      w_q_valid;
    logic      w_wr;

    assign o_cfg_ready = 1'b1;
    assign w_wr        = i_cfg_valid && o_cfg_ready;
    assign w_fv.load   = w_wr && (t_cfg_idx'(i_cfg_index) == CFG_FIRST_VALUE);
    assign w_fv.value  = i_cfg_data[BYTE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_bytes  <= LB_W'(40);
            r_cfg.tile_rows   <= TR_W'(1);
            r_cfg.tile_height <= TH_W'(8);
            r_cfg.plane_count <= PC_W'(1);
        end else if (w_wr) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LINE_BYTES:  r_cfg.line_bytes  <= i_cfg_data[LB_W-1:0];
                CFG_TILE_ROWS:   r_cfg.tile_rows   <= i_cfg_data[TR_W-1:0];
                CFG_TILE_HEIGHT: r_cfg.tile_height <= i_cfg_data[TH_W-1:0];
                CFG_PLANE_COUNT: r_cfg.plane_count <= i_cfg_data[PC_W-1:0];
                default: ;
            endcase
        end
    end

    tmbu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_fv          (w_fv),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_reload_mask (i_reload_mask),
        .i_mask_byte   (i_mask_byte),
        .i_value_bytes (i_value_bytes),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_entry       (w_push_entry)
    );

    tmbu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_entry (w_head)
    );

    tmbu_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_valid       (w_q_valid),
        .i_q_entry       (w_head),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_plane         (o_plane),
        .o_byte_index    (o_byte_index),
        .o_pixel_byte    (o_pixel_byte),
        .o_last_of_group (o_last_of_group),
        .o_picture_done  (o_picture_done)
    );

endmodule
